// ===== rtl/first_fit_heap_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Concurrent checks on the rising clock edge, switched off in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, quiet while reset is applied.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, quiet while reset is applied.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg)
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int ADDR_W   = 10;
  localparam int SIZE_W   = 10;
  localparam int STATUS_W = 3;

  localparam int HEAP_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC   = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_FREED   = 3'd2,
    ST_NULL    = 3'd3,
    ST_BADADDR = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_WRNEW,
    S_FNEXT,
    S_SHDN
  } state_e;

  // Compare results of the block unit for the entry being looked at.
  typedef struct packed {
    logic fit;  // free and long enough for the request
    logic big;  // long enough to be split
    logic hit;  // payload start equals the address to free
  } ffha_flags_t;

endpackage

// ===== rtl/first_fit_heap_allocator_top.sv =====
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_top_assert.svh"
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over a fixed heap, kept as an address-ordered block
// table in a single RAM and worked by a small sequencer.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; its result
// appears on result_addr_o and status_o, marked by done_o for a single
// cycle, and cannot be held off. The block table RAM moves one entry per
// cycle: a request scans the entries in order until one matches, a split
// then opens a slot by moving the later entries up and writes the new
// entry, and a free of any block but the last looks at its neighbour and,
// when it merges with a free one, closes the slot by moving any later
// entries down; a request that matches nothing scans all count entries.
// The result beat is registered from the last working state. A null free
// answers in the cycle after it is taken. After reset the block writes the
// initial table entry in its S_INIT state while busy is high.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top
  import ffha_pkg::*;
#(
  parameter int HeapBytes   = HEAP_BYTES_DEF,
  parameter int HeaderBytes = HEADER_BYTES_DEF,
  parameter int MaxBlocks   = MAX_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [SIZE_W-1:0]   req_size_i,
  input  logic [ADDR_W-1:0]   payload_addr_i,
  output logic                done_o,
  output logic [ADDR_W-1:0]   result_addr_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int AW = $clog2(HeapBytes + 1);
  localparam int IW = $clog2(MaxBlocks);
  localparam int CW = $clog2(MaxBlocks + 1);
  localparam int EW = 2 * AW + 1;

  state_e state_q, state_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     k_q, k_d;
  logic [CW-1:0]     count_q, count_d;
  logic              done_q, done_d;
  logic              kind_q, kind_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] paddr_q, paddr_d;
  logic [AW-1:0]     nstart_q, nstart_d;
  logic [AW-1:0]     nlen_q, nlen_d;
  logic [AW-1:0]     cstart_q, cstart_d;
  logic [AW-1:0]     clen_q, clen_d;
  logic [ADDR_W-1:0] raddr_q, raddr_d;
  status_e           status_q, status_d;

  logic          ram_we;
  logic [IW-1:0] ram_wa;
  logic [EW-1:0] ram_wd;
  logic [IW-1:0] ram_ra;
  logic [EW-1:0] ram_rd;

  logic [AW-1:0]     e_start;
  logic [AW-1:0]     e_len;
  logic              e_used;
  ffha_flags_t       flags;
  logic [ADDR_W-1:0] grant_addr;
  logic [AW-1:0]     split_start;
  logic [AW-1:0]     split_len;
  logic [AW-1:0]     merge_len;

  logic accept;
  logic null_free;
  logic alloc_hit;
  logic free_hit;
  logic split_go;
  logic last_scan;
  logic shup_last;
  logic merge_last;
  logic shdn_last;

  assign e_start = ram_rd[EW-1 -: AW];
  assign e_len   = ram_rd[AW:1];
  assign e_used  = ram_rd[0];

  ffha_ram #(
    .Width (EW),
    .Depth (MaxBlocks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  ffha_unit #(
    .AddrW       (AW),
    .HeaderBytes (HeaderBytes)
  ) u_unit (
    .start_i       (e_start),
    .len_i         (e_len),
    .used_i        (e_used),
    .size_i        (size_q),
    .paddr_i       (paddr_q),
    .acc_len_i     (clen_q),
    .flags_o       (flags),
    .grant_addr_o  (grant_addr),
    .split_start_o (split_start),
    .split_len_o   (split_len),
    .merge_len_o   (merge_len)
  );

  assign busy       = state_q != S_IDLE;
  assign accept     = start && !busy;
  assign null_free  = (kind_i == KIND_FREE) && (payload_addr_i == '0);
  assign alloc_hit  = (kind_q == KIND_ALLOC) && flags.fit;
  assign free_hit   = (kind_q == KIND_FREE) && flags.hit;
  assign split_go   = flags.big && (count_q != CW'(MaxBlocks));
  assign last_scan  = (CW'(idx_q) + CW'(1)) == count_q;
  assign shup_last  = k_q == (idx_q + IW'(2));
  assign merge_last = (CW'(idx_q) + CW'(2)) == count_q;
  assign shdn_last  = (CW'(k_q) + CW'(2)) == count_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept && !null_free) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (alloc_hit) begin
          if (!split_go) begin
            state_d = S_IDLE;
          end else if (last_scan) begin
            state_d = S_WRNEW;
          end else begin
            state_d = S_SHUP;
          end
        end else if (free_hit) begin
          state_d = last_scan ? S_IDLE : S_FNEXT;
        end else if (last_scan) begin
          state_d = S_IDLE;
        end
      end
      S_SHUP: begin
        if (shup_last) begin
          state_d = S_WRNEW;
        end
      end
      S_WRNEW: begin
        state_d = S_IDLE;
      end
      S_FNEXT: begin
        state_d = (!e_used && !merge_last) ? S_SHDN : S_IDLE;
      end
      S_SHDN: begin
        if (shdn_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // Table access, counters and result.
  always_comb begin
    ram_we   = 1'b0;
    ram_wa   = idx_q;
    ram_wd   = '0;
    ram_ra   = idx_q + IW'(1);
    idx_d    = idx_q;
    k_d      = k_q;
    count_d  = count_q;
    done_d   = 1'b0;
    kind_d   = kind_q;
    size_d   = size_q;
    paddr_d  = paddr_q;
    nstart_d = nstart_q;
    nlen_d   = nlen_q;
    cstart_d = cstart_q;
    clen_d   = clen_q;
    raddr_d  = raddr_q;
    status_d = status_q;
    case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        ram_wa = '0;
        ram_wd = {AW'(0), AW'(HeapBytes - HeaderBytes), 1'b0};
        ram_ra = '0;
      end
      S_IDLE: begin
        ram_ra = '0;
        if (accept) begin
          kind_d  = kind_i;
          size_d  = req_size_i;
          paddr_d = payload_addr_i;
          idx_d   = '0;
          if (null_free) begin
            done_d   = 1'b1;
            raddr_d  = '0;
            status_d = ST_NULL;
          end
        end
      end
      S_SCAN: begin
        if (alloc_hit) begin
          raddr_d  = grant_addr;
          status_d = ST_ALLOC;
          ram_we   = 1'b1;
          ram_wd   = {e_start, (split_go ? AW'(size_q) : e_len), 1'b1};
          if (split_go) begin
            nstart_d = split_start;
            nlen_d   = split_len;
            k_d      = IW'(count_q);
            // Fetch the top entry so that the slot opening can start at once.
            ram_ra   = IW'(count_q - CW'(1));
          end else begin
            done_d = 1'b1;
          end
        end else if (free_hit) begin
          raddr_d  = '0;
          status_d = ST_FREED;
          ram_we   = 1'b1;
          ram_wd   = {e_start, e_len, 1'b0};
          cstart_d = e_start;
          clen_d   = e_len;
          if (last_scan) begin
            done_d = 1'b1;
          end
        end else if (last_scan) begin
          done_d   = 1'b1;
          raddr_d  = '0;
          status_d = (kind_q == KIND_ALLOC) ? ST_NOSPACE : ST_BADADDR;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_SHUP: begin
        ram_we = 1'b1;
        ram_wa = k_q;
        ram_wd = ram_rd;
        ram_ra = k_q - IW'(2);
        if (!shup_last) begin
          k_d = k_q - IW'(1);
        end
      end
      S_WRNEW: begin
        ram_we  = 1'b1;
        ram_wa  = idx_q + IW'(1);
        ram_wd  = {nstart_q, nlen_q, 1'b0};
        count_d = count_q + CW'(1);
        done_d  = 1'b1;
      end
      S_FNEXT: begin
        // The read data now holds the entry after the freed one.
        if (!e_used) begin
          ram_we = 1'b1;
          ram_wd = {cstart_q, merge_len, 1'b0};
          ram_ra = idx_q + IW'(2);
          k_d    = idx_q + IW'(1);
          if (merge_last) begin
            count_d = count_q - CW'(1);
            done_d  = 1'b1;
          end
        end else begin
          done_d = 1'b1;
        end
      end
      S_SHDN: begin
        ram_we = 1'b1;
        ram_wa = k_q;
        ram_wd = ram_rd;
        ram_ra = k_q + IW'(2);
        if (shdn_last) begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      default: begin
        ram_ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      idx_q   <= '0;
      k_q     <= '0;
      count_q <= CW'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    size_q   <= size_d;
    paddr_q  <= paddr_d;
    nstart_q <= nstart_d;
    nlen_q   <= nlen_d;
    cstart_q <= cstart_d;
    clen_q   <= clen_d;
    raddr_q  <= raddr_d;
    status_q <= status_d;
  end

  assign done_o        = done_q;
  assign result_addr_o = raddr_q;
  assign status_o      = status_q;

  `FFHA_ASSERT_NOW(a_count_range, 1'b1, (count_q != '0) && (count_q <= CW'(MaxBlocks)), "block count out of range")
  `FFHA_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result beat while the sequencer is still working")
  `FFHA_ASSERT_NEXT(a_accept_busy, accept && !null_free, busy, "request beat taken without going busy")
  `FFHA_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, CW'(idx_q) < count_q, "scan index past the last block")

endmodule

// ===== rtl/ffha_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ffha_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_unit
// Shared add and compare unit applied to one block table entry per cycle.
// ----------------------------------------------------------------------------
module ffha_unit
  import ffha_pkg::*;
#(
  parameter int AddrW       = 11,
  parameter int HeaderBytes = HEADER_BYTES_DEF
) (
  input  logic [AddrW-1:0]  start_i,
  input  logic [AddrW-1:0]  len_i,
  input  logic              used_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [AddrW-1:0]  acc_len_i,
  output ffha_flags_t       flags_o,
  output logic [ADDR_W-1:0] grant_addr_o,
  output logic [AddrW-1:0]  split_start_o,
  output logic [AddrW-1:0]  split_len_o,
  output logic [AddrW-1:0]  merge_len_o
);

  localparam int CalcW = ((AddrW > SIZE_W) ? AddrW : SIZE_W) + 1;

  logic [CalcW-1:0] hdr;
  logic [CalcW-1:0] len_x;
  logic [CalcW-1:0] size_x;
  logic [CalcW-1:0] need;
  logic [CalcW-1:0] pay;

  assign hdr    = CalcW'(HeaderBytes);
  assign len_x  = CalcW'(len_i);
  assign size_x = CalcW'(size_i);
  assign need   = size_x + hdr;
  assign pay    = CalcW'(start_i) + hdr;

  assign flags_o.fit = !used_i && (len_x >= size_x);
  assign flags_o.big = len_x > need;
  assign flags_o.hit = pay == CalcW'(paddr_i);

  assign grant_addr_o  = pay[ADDR_W-1:0];
  assign split_start_o = AddrW'(pay + size_x);
  assign split_len_o   = AddrW'(len_x - need);
  assign merge_len_o   = AddrW'(CalcW'(acc_len_i) + hdr + len_x);

endmodule
